[sv/whp_pkg.sv]
// Shared types and constants for the RIFF/WAVE header parser.
// No dependencies; used by every module of the block.
package whp_pkg;

  // Stream position counter width (16 to 32)
  localparam int POS_W = 32;

  localparam int FIELD16_W = 16;
  localparam int FIELD32_W = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_ADDR_W = 8;

  // Chunk tags, first byte in the high bits
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_EXPECT_FORMAT   = 8'd0,
    CFG_EXPECT_CHANNELS = 8'd1,
    CFG_EXPECT_RATE     = 8'd2,
    CFG_EXPECT_BITS     = 8'd3
  } cfg_idx_t;

  localparam logic [15:0] RST_EXPECT_FORMAT   = 16'd1;
  localparam logic [15:0] RST_EXPECT_CHANNELS = 16'd2;
  localparam logic [31:0] RST_EXPECT_RATE     = 32'd44100;
  localparam logic [15:0] RST_EXPECT_BITS     = 16'd16;

  // Parse phases, one-hot
  typedef enum logic [7:0] {
    PH_RIFF  = 8'b0000_0001,
    PH_RSIZE = 8'b0000_0010,
    PH_WAVE  = 8'b0000_0100,
    PH_ID    = 8'b0000_1000,
    PH_SIZE  = 8'b0001_0000,
    PH_FMT   = 8'b0010_0000,
    PH_SKIP  = 8'b0100_0000,
    PH_DONE  = 8'b1000_0000
  } phase_t;

  // Known-good expectations
  typedef struct packed {
    logic [15:0] format;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [15:0] bits;
  } expect_t;

  // Result item; packed so riff_ok lands in bit 0
  typedef struct packed {
    logic [2:0]  pad;
    logic        known_good;
    logic [31:0] data_size;
    logic [31:0] data_offset;
    logic [15:0] sample_bits;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    logic [15:0] audio_format;
    logic        data_found;
    logic        fmt_found;
    logic        wave_ok;
    logic        riff_ok;
  } result_t;

  localparam int RES_W = $bits(result_t);

endpackage

[sv/whp_parser.sv]
// Byte-wise RIFF/WAVE chunk walker: phase, counters, shift registers and
// captured fields. Depends on whp_pkg.
module whp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,        // item accepted this cycle
  input  logic [7:0]        data_byte,
  input  logic              stream_end,
  input  whp_pkg::expect_t  expect_cfg,
  output logic              res_valid,
  output whp_pkg::result_t  res
);
  import whp_pkg::*;

  phase_t       phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [4:0]   cnt_r, cnt_nxt;
  logic [31:0]  tag_r, tag_nxt;
  logic [31:0]  size_r, size_nxt;
  logic [32:0]  skip_r, skip_nxt;
  logic         is_fmt_r, is_fmt_nxt;
  logic [15:0]  fmt_r, fmt_nxt;
  logic [15:0]  ch_r, ch_nxt;
  logic [31:0]  rate_r, rate_nxt;
  logic [15:0]  bits_r, bits_nxt;
  logic [3:0]   flags_r, flags_nxt;
  logic [31:0]  off_r, off_nxt;
  logic [31:0]  dsize_r, dsize_nxt;
  logic         given_r, given_nxt;

  logic [4:0]   cnt_inc;
  logic [31:0]  tag_shl, tag_shr, size_sh;
  logic [32:0]  skip_new, skip_dec;
  logic         hdr_done;
  logic         end_data, end_fmt;
  logic [3:0]   e_flags;
  logic [15:0]  e_fmt, e_ch, e_bits;
  logic [31:0]  e_rate, e_off, e_size;

  assign cnt_inc  = cnt_r + 5'd1;
  assign tag_shl  = {tag_r[23:0], data_byte};
  assign tag_shr  = {data_byte, tag_r[31:8]};
  assign size_sh  = {data_byte, size_r[31:8]};
  assign skip_new = {1'b0, size_sh} + {32'd0, size_sh[0]};
  assign skip_dec = skip_r - 33'd1;

  // Data chunk header just completed
  assign hdr_done = acc && !stream_end && (phase_r == PH_SIZE) &&
                    (cnt_r == 5'd3) && (tag_r == TAG_DATA);

  // Stream end inside a chunk size still records the chunk id
  assign end_data = (phase_r == PH_SIZE) && (tag_r == TAG_DATA);
  assign end_fmt  = (phase_r == PH_SIZE) && (tag_r == TAG_FMT);

  // Next state of the walker
  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    tag_nxt    = tag_r;
    size_nxt   = size_r;
    skip_nxt   = skip_r;
    is_fmt_nxt = is_fmt_r;
    fmt_nxt    = fmt_r;
    ch_nxt     = ch_r;
    rate_nxt   = rate_r;
    bits_nxt   = bits_r;
    flags_nxt  = flags_r;
    off_nxt    = off_r;
    dsize_nxt  = dsize_r;
    given_nxt  = given_r;
    if (acc && stream_end) begin
      phase_nxt  = PH_RIFF;
      pos_nxt    = '0;
      cnt_nxt    = '0;
      tag_nxt    = '0;
      size_nxt   = '0;
      skip_nxt   = '0;
      is_fmt_nxt = 1'b0;
      fmt_nxt    = '0;
      ch_nxt     = '0;
      rate_nxt   = '0;
      bits_nxt   = '0;
      flags_nxt  = '0;
      off_nxt    = '0;
      dsize_nxt  = '0;
      given_nxt  = 1'b0;
    end else if (acc && (phase_r != PH_DONE)) begin
      pos_nxt = pos_r + POS_W'(1);
      case (phase_r)
        PH_RIFF, PH_WAVE, PH_ID: begin
          tag_nxt = tag_shl;
          cnt_nxt = cnt_inc;
          if (cnt_r == 5'd3) begin
            cnt_nxt = '0;
            if (phase_r == PH_RIFF) begin
              if (tag_shl == TAG_RIFF) flags_nxt[0] = 1'b1;
              phase_nxt = PH_RSIZE;
            end else if (phase_r == PH_WAVE) begin
              if (tag_shl == TAG_WAVE) flags_nxt[1] = 1'b1;
              tag_nxt   = '0;
              phase_nxt = PH_ID;
            end else begin
              is_fmt_nxt = (tag_shl == TAG_FMT);
              size_nxt   = '0;
              phase_nxt  = PH_SIZE;
            end
          end
        end
        PH_RSIZE: begin
          cnt_nxt = cnt_inc;
          if (cnt_r == 5'd3) begin
            cnt_nxt   = '0;
            tag_nxt   = '0;
            phase_nxt = PH_WAVE;
          end
        end
        PH_SIZE: begin
          size_nxt = size_sh;
          cnt_nxt  = cnt_inc;
          if (cnt_r == 5'd3) begin
            cnt_nxt = '0;
            if (tag_r == TAG_DATA) begin
              flags_nxt[3] = 1'b1;
              off_nxt      = 32'(pos_nxt);
              dsize_nxt    = size_sh;
              given_nxt    = 1'b1;
              phase_nxt    = PH_DONE;
            end else begin
              skip_nxt = skip_new;
              tag_nxt  = '0;
              if (is_fmt_r) begin
                flags_nxt[2] = 1'b1;
                fmt_nxt  = '0;
                ch_nxt   = '0;
                rate_nxt = '0;
                bits_nxt = '0;
              end
              if (is_fmt_r && (size_sh != 32'd0)) begin
                phase_nxt = PH_FMT;
              end else begin
                phase_nxt = (skip_new == 33'd0) ? PH_ID : PH_SKIP;
              end
            end
          end
        end
        PH_FMT: begin
          tag_nxt  = tag_shr;
          cnt_nxt  = cnt_inc;
          skip_nxt = skip_dec;
          case (cnt_inc)
            5'd2:    fmt_nxt  = tag_shr[31:16];
            5'd4:    ch_nxt   = tag_shr[31:16];
            5'd8:    rate_nxt = tag_shr;
            5'd16:   bits_nxt = tag_shr[31:16];
            default: ;
          endcase
          if ((cnt_inc >= 5'd16) || (32'(cnt_inc) == size_r)) begin
            cnt_nxt   = '0;
            tag_nxt   = '0;
            phase_nxt = (skip_dec == 33'd0) ? PH_ID : PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (skip_r != 33'd0) skip_nxt = skip_dec;
          if ((skip_r == 33'd0) || (skip_dec == 33'd0)) begin
            cnt_nxt   = '0;
            tag_nxt   = '0;
            phase_nxt = PH_ID;
          end
        end
        default: ;
      endcase
    end
  end

  // Walker registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_RIFF;
      pos_r    <= '0;
      cnt_r    <= '0;
      tag_r    <= '0;
      size_r   <= '0;
      skip_r   <= '0;
      is_fmt_r <= 1'b0;
      fmt_r    <= '0;
      ch_r     <= '0;
      rate_r   <= '0;
      bits_r   <= '0;
      flags_r  <= '0;
      off_r    <= '0;
      dsize_r  <= '0;
      given_r  <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      cnt_r    <= cnt_nxt;
      tag_r    <= tag_nxt;
      size_r   <= size_nxt;
      skip_r   <= skip_nxt;
      is_fmt_r <= is_fmt_nxt;
      fmt_r    <= fmt_nxt;
      ch_r     <= ch_nxt;
      rate_r   <= rate_nxt;
      bits_r   <= bits_nxt;
      flags_r  <= flags_nxt;
      off_r    <= off_nxt;
      dsize_r  <= dsize_nxt;
      given_r  <= given_nxt;
    end
  end

  // Result values seen at the emitting item
  always_comb begin
    e_flags = flags_r;
    e_fmt   = fmt_r;
    e_ch    = ch_r;
    e_rate  = rate_r;
    e_bits  = bits_r;
    e_off   = off_r;
    e_size  = dsize_r;
    if (hdr_done) begin
      e_flags[3] = 1'b1;
      e_off      = 32'(pos_nxt);
      e_size     = size_sh;
    end else if (end_data) begin
      e_flags[3] = 1'b1;
      e_off      = 32'(pos_r);
      e_size     = '0;
    end else if (end_fmt) begin
      e_flags[2] = 1'b1;
      e_fmt      = '0;
      e_ch       = '0;
      e_rate     = '0;
      e_bits     = '0;
    end
  end

  assign res_valid = hdr_done || (acc && stream_end && !given_r);

  always_comb begin
    res               = '0;
    res.riff_ok       = e_flags[0];
    res.wave_ok       = e_flags[1];
    res.fmt_found     = e_flags[2];
    res.data_found    = e_flags[3];
    res.audio_format  = e_fmt;
    res.channel_count = e_ch;
    res.sample_rate   = e_rate;
    res.sample_bits   = e_bits;
    res.data_offset   = e_off;
    res.data_size     = e_size;
    res.known_good    = (e_flags == 4'hF) && (e_fmt == expect_cfg.format) &&
                        (e_ch == expect_cfg.channels) &&
                        (e_rate == expect_cfg.rate) && (e_bits == expect_cfg.bits);
  end

`ifndef SYNTH
  // Stream end always returns the walker to the start of a file
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && stream_end |=> (phase_r == PH_RIFF) && (pos_r == '0) && !given_r)
    else $error("parser not cleared after stream end");

  // Done phase and the result-given mark travel together
  a_done_given: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE) == given_r)
    else $error("done phase and result mark disagree");

  // A header completion sets the mark so no second result follows
  a_hdr_marks: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_done |=> given_r && flags_r[3])
    else $error("data header did not mark result given");
`endif

endmodule

[sv/whp_out_buf.sv]
// Two-entry result buffer (output register plus skid stage) for the parser.
// Depends on whp_pkg.
module whp_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  whp_pkg::result_t push_data,
  output logic             can_accept,
  output logic             out_valid,
  input  logic             out_ready,
  output whp_pkg::result_t out_data
);
  import whp_pkg::*;

  logic    out_v_r, out_v_nxt;
  logic    sk_v_r, sk_v_nxt;
  result_t out_d_r, out_d_nxt;
  result_t sk_d_r, sk_d_nxt;
  logic    pop;

  assign pop        = out_v_r && out_ready;
  assign can_accept = !sk_v_r;
  assign out_valid  = out_v_r;
  assign out_data   = out_d_r;

  // Fill the output register first, park in the skid stage when it is stalled
  always_comb begin
    out_v_nxt = out_v_r;
    sk_v_nxt  = sk_v_r;
    out_d_nxt = out_d_r;
    sk_d_nxt  = sk_d_r;
    if (sk_v_r) begin
      if (pop) begin
        out_d_nxt = sk_d_r;
        sk_v_nxt  = 1'b0;
      end
    end else if (push) begin
      if (!out_v_r || pop) begin
        out_d_nxt = push_data;
        out_v_nxt = 1'b1;
      end else begin
        sk_d_nxt = push_data;
        sk_v_nxt = 1'b1;
      end
    end else if (pop) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      sk_v_r  <= sk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r <= out_d_nxt;
    sk_d_r  <= sk_d_nxt;
  end

`ifndef SYNTH
  // Skid stage only holds an item behind a full output register
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    sk_v_r |-> out_v_r)
    else $error("skid stage valid with empty output register");

  // No push arrives while both entries are taken
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !sk_v_r)
    else $error("result pushed into full buffer");

  // A stalled output with a pushed item lands that item in the skid stage
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    push && out_v_r && !out_ready |=> sk_v_r && (sk_d_r == $past(push_data)))
    else $error("stalled result not parked");
`endif

endmodule

[sv/wav_header_parser.sv]
// Top level of the RIFF/WAVE header parser: configuration registers,
// chunk walker and result buffer. Depends on whp_pkg, whp_parser, whp_out_buf.
//
// Feed the file one byte per item on in_tdata; raise in_tlast on an extra
// item to mark the end of the stream (its byte is ignored and the parser
// returns to its start state). A new byte can be accepted every cycle while
// the result buffer has room: the walker's phase, counters and shift registers
// update in the cycle the byte is accepted. At most one result is produced
// per file, when the data chunk header completes or at stream end; it is
// held in a two-entry output buffer, so input stalls only when two results
// wait on a stalled output. Write the cfg_ registers only while no file is
// being parsed and no result is pending.
module wav_header_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,  // [7:0] data_byte
  input  logic                          in_tlast,  // stream_end
  // Result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [0] riff_ok, [1] wave_ok, [2] fmt_found, [3] data_found,
  // [19:4] audio_format, [35:20] channel_count, [67:36] sample_rate,
  // [83:68] sample_bits, [115:84] data_offset, [147:116] data_size,
  // [148] known_good, [151:149] zero
  output logic [whp_pkg::RES_W-1:0]     out_tdata,
  // Configuration writes
  input  logic                          cfg_wen,
  input  logic [whp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [whp_pkg::CFG_W-1:0]     cfg_wdata
);
  import whp_pkg::*;

  expect_t exp_r;
  logic    acc;
  logic    buf_ready;
  logic    res_valid;
  result_t res;
  result_t out_res;

  // Expectation registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r.format   <= RST_EXPECT_FORMAT;
      exp_r.channels <= RST_EXPECT_CHANNELS;
      exp_r.rate     <= RST_EXPECT_RATE;
      exp_r.bits     <= RST_EXPECT_BITS;
    end else if (cfg_wen) begin
      case (cfg_addr)
        CFG_EXPECT_FORMAT:   exp_r.format   <= cfg_wdata[15:0];
        CFG_EXPECT_CHANNELS: exp_r.channels <= cfg_wdata[15:0];
        CFG_EXPECT_RATE:     exp_r.rate     <= cfg_wdata;
        CFG_EXPECT_BITS:     exp_r.bits     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign in_tready = buf_ready;
  assign acc       = in_tvalid && buf_ready;

  whp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .data_byte  (in_tdata),
    .stream_end (in_tlast),
    .expect_cfg (exp_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  whp_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .can_accept (buf_ready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res)
  );

  assign out_tdata = out_res;

endmodule
